// ===== hdl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, field widths and calendar helpers for the calendar clock.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned MS_W     = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TICKS_W  = 16;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [SECOND_W:0] SECOND_MAX = 7'd59;
  localparam logic [MINUTE_W:0] MINUTE_MAX = 7'd59;
  localparam logic [HOUR_W:0]   HOUR_MAX   = 6'd23;
  localparam logic [DAY_W:0]    DAY_CHECK  = 6'd28;
  localparam logic [MONTH_W:0]  MONTH_MAX  = 5'd12;
  localparam logic [MS_W-1:0]   MS_SAT     = 10'd1023;

  // divisibility by 25: multiply by the inverse of 25 modulo 2^16
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } dt_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div25;
    p     = y * INV25;
    div25 = (p <= DIV25_MAX);
    // div by 4, and a century year only when also div by 16 (so by 400)
    return (y != '0) && (y[1:0] == 2'b00) && !(div25 && (y[3:0] != 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0]  y);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/ccc_step.sv =====
// ----------------------------------------------------------------------------
// ccc_step
// Next-state logic: one-second cascade, load, stamp and millisecond count.
// ----------------------------------------------------------------------------
module ccc_step (
  input  logic                          op_i,
  input  logic [ccc_pkg::TIME_W-1:0]    now_i,
  input  ccc_pkg::dt_t                  load_i,
  input  ccc_pkg::dt_t                  cur_i,
  input  logic [ccc_pkg::TIME_W-1:0]    stamp_i,
  input  logic [ccc_pkg::TICKS_W-1:0]   ticks_i,
  output ccc_pkg::dt_t                  nxt_o,
  output logic [ccc_pkg::TIME_W-1:0]    stamp_o,
  output logic [ccc_pkg::MS_W-1:0]      millis_o
);
  import ccc_pkg::*;

  logic [TIME_W-1:0]   diff;
  logic                tick;
  logic [SECOND_W:0]   sec_inc;
  logic [MINUTE_W:0]   min_inc;
  logic [HOUR_W:0]     hour_inc;
  logic [DAY_W:0]      day_inc;
  logic [MONTH_W:0]    mon_inc;
  logic                day_roll;
  dt_t                 adv;

  assign diff     = now_i - stamp_i;
  assign tick     = (diff >= TIME_W'(ticks_i));
  assign sec_inc  = {1'b0, cur_i.second} + 1'b1;
  assign min_inc  = {1'b0, cur_i.minute} + 1'b1;
  assign hour_inc = {1'b0, cur_i.hour} + 1'b1;
  assign day_inc  = {1'b0, cur_i.day} + 1'b1;
  assign mon_inc  = {1'b0, cur_i.month} + 1'b1;
  assign day_roll = (day_inc > DAY_CHECK) &&
                    (day_inc > {1'b0, month_len(cur_i.month, cur_i.year)});

  always_comb begin
    adv = cur_i;
    if (sec_inc <= SECOND_MAX) begin
      adv.second = sec_inc[SECOND_W-1:0];
    end else begin
      adv.second = '0;
      if (min_inc <= MINUTE_MAX) begin
        adv.minute = min_inc[MINUTE_W-1:0];
      end else begin
        adv.minute = '0;
        if (hour_inc <= HOUR_MAX) begin
          adv.hour = hour_inc[HOUR_W-1:0];
        end else begin
          adv.hour = '0;
          if (day_roll) begin
            adv.day = DAY_W'(1);
            if (mon_inc > MONTH_MAX) begin
              adv.month = MONTH_W'(1);
              adv.year  = cur_i.year + 1'b1;
            end else begin
              adv.month = mon_inc[MONTH_W-1:0];
            end
          end else begin
            adv.day = day_inc[DAY_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    nxt_o    = cur_i;
    stamp_o  = stamp_i;
    millis_o = '0;
    if (op_i == OP_LOAD) begin
      nxt_o = load_i;
    end else if (tick) begin
      nxt_o   = adv;
      stamp_o = now_i;
    end else if (diff > TIME_W'(MS_SAT)) begin
      millis_o = MS_SAT;
    end else begin
      millis_o = diff[MS_W-1:0];
    end
  end

endmodule

// ===== hdl/calendar_clock_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_counter
// Calendar clock advanced one second by an update once a second has elapsed, with date load.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                    tuser
//  s_axis    in   now_ms, year, month, day, hour, min, sec operation
//  m_axis    out  year, month, day, hour, min, sec, ms     -
//
//  One request per cycle unless stalled; a result passes the input register,
//  then the result register, which is updated with the calendar state.
//  Reset clears the calendar, the stamp and both valid flags.
//  A stalled result holds the input register; s_axis_tready drops only
//  while both registers are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module calendar_clock_counter #(
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms[31:0], year[47:32], month[51:48], day[56:52], hour[61:57],
  // minute[67:62], second[73:68], zero pad
  input  logic [ccc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // year[15:0], month[19:16], day[24:20], hour[29:25], minute[35:30],
  // second[41:36], millisecond[51:42], zero pad
  output logic [ccc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import ccc_pkg::*;

  localparam logic [TICKS_W-1:0] TICKS = TICKS_W'(TICKS_PER_SECOND);

  logic                in_valid_q;
  logic                in_op_q;
  logic [TIME_W-1:0]   in_now_q;
  dt_t                 in_load_q;
  dt_t                 load_in;

  dt_t                 cur_q, cur_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;
  logic [MS_W-1:0]     millis_d;

  logic                out_valid_q;
  dt_t                 out_dt_q;
  logic [MS_W-1:0]     out_ms_q;

  logic                adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  assign load_in.year   = s_axis_tdata[47:32];
  assign load_in.month  = s_axis_tdata[51:48];
  assign load_in.day    = s_axis_tdata[56:52];
  assign load_in.hour   = s_axis_tdata[61:57];
  assign load_in.minute = s_axis_tdata[67:62];
  assign load_in.second = s_axis_tdata[73:68];

  ccc_step u_step (
    .op_i     (in_op_q),
    .now_i    (in_now_q),
    .load_i   (in_load_q),
    .cur_i    (cur_q),
    .stamp_i  (stamp_q),
    .ticks_i  (TICKS),
    .nxt_o    (cur_d),
    .stamp_o  (stamp_d),
    .millis_o (millis_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= '0;
      stamp_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        cur_q       <= cur_d;
        stamp_q     <= stamp_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tuser;
      in_now_q  <= s_axis_tdata[TIME_W-1:0];
      in_load_q <= load_in;
    end
    if (adv) begin
      out_dt_q <= cur_d;
      out_ms_q <= millis_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_ms_q, out_dt_q.second, out_dt_q.minute,
                          out_dt_q.hour, out_dt_q.day, out_dt_q.month,
                          out_dt_q.year};

endmodule

// ===== hdl/ccc_checker.sv =====
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks for the calendar clock, bound to the top level.
// ----------------------------------------------------------------------------
module ccc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ccc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a request into an empty output reaches the result register behind the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after request");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/calendar_clock_counter_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_counter_tb
// Drives update and load requests into the calendar clock, predicts every
// date/time reading from its own calendar state and compares each returned
// reading field by field. Directed tests hit tick thresholds, time wrap,
// full cascades, leap years and out-of-range loads; random traffic then
// loads near-rollover dates and walks time forward under varying stalls.
// ----------------------------------------------------------------------------
module calendar_clock_counter_tb;
  import ccc_pkg::*;

  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned MAX_PRINTS       = 40;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [MS_W-1:0]     millis;
  } reading_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // calendar predictor state
  logic [TIME_W-1:0] tick_stamp = '0;
  dt_t               cal_now    = '0;
  logic [MS_W-1:0]   cal_ms     = '0;

  reading_t          expected_readings[$];
  logic [TIME_W-1:0] now_t        = '0;
  int unsigned       sent_count   = 0;
  int unsigned       fail_count   = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       src_idle_pct = 0;
  int unsigned       snk_idle_pct = 0;

  always #6 clk_i = ~clk_i;

  calendar_clock_counter #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
    return (y != 0) && (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic [YEAR_W-1:0]  y);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd2:    return is_leap_year(y) ? 5'd29 : 5'd28;
      default: return 5'd30;
    endcase
  endfunction

  function automatic void add_one_second();
    logic [SECOND_W:0] s;
    logic [MINUTE_W:0] mi;
    logic [HOUR_W:0]   h;
    logic [DAY_W:0]    d;
    logic [MONTH_W:0]  mo;
    s = {1'b0, cal_now.second} + 1'b1;
    if (s <= 59) begin
      cal_now.second = s[SECOND_W-1:0];
      return;
    end
    cal_now.second = '0;
    mi = {1'b0, cal_now.minute} + 1'b1;
    if (mi <= 59) begin
      cal_now.minute = mi[MINUTE_W-1:0];
      return;
    end
    cal_now.minute = '0;
    h = {1'b0, cal_now.hour} + 1'b1;
    if (h <= 23) begin
      cal_now.hour = h[HOUR_W-1:0];
      return;
    end
    cal_now.hour = '0;
    d = {1'b0, cal_now.day} + 1'b1;
    if (d > 28 && d > {1'b0, days_in(cal_now.month, cal_now.year)}) begin
      mo = {1'b0, cal_now.month} + 1'b1;
      if (mo > 12) begin
        cal_now.year = cal_now.year + 1'b1;
        mo = 5'd1;
      end
      cal_now.month = mo[MONTH_W-1:0];
      d = 6'd1;
    end
    cal_now.day = d[DAY_W-1:0];
  endfunction

  function automatic reading_t predict_reading(input op_e op, input logic [TIME_W-1:0] now,
                                               input dt_t ld);
    logic [TIME_W-1:0] diff;
    reading_t          r;
    if (op == OP_LOAD) begin
      cal_now = ld;
      cal_ms  = '0;
    end else begin
      diff = now - tick_stamp;
      if (diff >= TICKS_PER_SECOND) begin
        add_one_second();
        tick_stamp = now;
        diff       = '0;
      end
      cal_ms = (diff > 1023) ? 10'd1023 : diff[MS_W-1:0];
    end
    r.year   = cal_now.year;
    r.month  = cal_now.month;
    r.day    = cal_now.day;
    r.hour   = cal_now.hour;
    r.minute = cal_now.minute;
    r.second = cal_now.second;
    r.millis = cal_ms;
    return r;
  endfunction

  function automatic dt_t mk_date(input int unsigned y, mo, d, h, mi, s);
    dt_t r;
    r.year   = y[YEAR_W-1:0];
    r.month  = mo[MONTH_W-1:0];
    r.day    = d[DAY_W-1:0];
    r.hour   = h[HOUR_W-1:0];
    r.minute = mi[MINUTE_W-1:0];
    r.second = s[SECOND_W-1:0];
    return r;
  endfunction

  function automatic dt_t random_date();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(dt_t)-1:0];
  endfunction

  function automatic dt_t near_rollover_date();
    dt_t r;
    r = random_date();
    case ($urandom_range(7))
      0:       r.year = 16'd0;
      1:       r.year = 16'hFFFF;
      2:       r.year = 16'd1900;
      3:       r.year = 16'd2000;
      4:       r.year = 16'd2100;
      5:       r.year = 16'($urandom_range(0, 16383) * 4);
      default: r.year = 16'($urandom_range(0, 65535));
    endcase
    r.month  = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 12));
    r.day    = ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(27, 31));
    r.hour   = ($urandom_range(3) != 0) ? 5'd23 : 5'($urandom_range(0, 31));
    r.minute = ($urandom_range(3) != 0) ? 6'd59 : 6'($urandom_range(0, 63));
    r.second = ($urandom_range(3) != 0) ? 6'd59 : 6'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] random_step();
    case ($urandom_range(9))
      0:       return 32'd1000;
      1:       return 32'd999;
      2:       return 32'd0;
      3, 4:    return $urandom_range(1000, 1999);
      5:       return $urandom_range(1, 998);
      6:       return $urandom_range(2000, 100000);
      7:       return 32'd1001;
      default: return $urandom_range(1000, 1100);
    endcase
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_request(input op_e op, input logic [TIME_W-1:0] now, input dt_t ld);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {6'd0, ld.second, ld.minute, ld.hour, ld.day, ld.month, ld.year, now};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_readings.push_back(predict_reading(op, now, ld));
    sent_count++;
  endtask

  task automatic send_load(input dt_t ld);
    send_request(OP_LOAD, $urandom, ld);
  endtask

  task automatic update_at(input logic [TIME_W-1:0] now);
    now_t = now;
    send_request(OP_UPDATE, now, random_date());
  endtask

  task automatic advance_and_update(input logic [TIME_W-1:0] step);
    update_at(now_t + step);
  endtask

  // result side: random backpressure, compare against oldest prediction
  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    reading_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.year   = m_axis_tdata[15:0];
      got.month  = m_axis_tdata[19:16];
      got.day    = m_axis_tdata[24:20];
      got.hour   = m_axis_tdata[29:25];
      got.minute = m_axis_tdata[35:30];
      got.second = m_axis_tdata[41:36];
      got.millis = m_axis_tdata[51:42];
      if (expected_readings.size() == 0) begin
        report_failure("reading with no pending request");
      end else begin
        want = expected_readings.pop_front();
        if (got.year !== want.year)
          report_failure($sformatf("year %0d, want %0d", got.year, want.year));
        if (got.month !== want.month)
          report_failure($sformatf("month %0d, want %0d", got.month, want.month));
        if (got.day !== want.day)
          report_failure($sformatf("day %0d, want %0d", got.day, want.day));
        if (got.hour !== want.hour)
          report_failure($sformatf("hour %0d, want %0d", got.hour, want.hour));
        if (got.minute !== want.minute)
          report_failure($sformatf("minute %0d, want %0d", got.minute, want.minute));
        if (got.second !== want.second)
          report_failure($sformatf("second %0d, want %0d", got.second, want.second));
        if (got.millis !== want.millis)
          report_failure($sformatf("millisecond %0d, want %0d", got.millis, want.millis));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL calendar_clock_counter");
      $finish;
    end
  end

  task automatic test_reset_state();
    update_at(32'd0);
    update_at(32'd999);
    update_at(32'd1000);
  endtask

  // exact threshold, stamp near the top of the time range, wrapped difference
  task automatic test_tick_threshold();
    update_at(32'd1999);
    update_at(32'd2000);
    update_at(32'hFFFF_FFFF);
    update_at(32'd998);
    update_at(32'd999);
  endtask

  task automatic test_rollover_cascade();
    send_load(mk_date(65535, 12, 31, 23, 59, 59));
    advance_and_update(32'd1000);
    send_load(mk_date(0, 0, 30, 23, 59, 59));
    advance_and_update(32'd1000);
  endtask

  task automatic test_leap_years();
    int unsigned years[4];
    years = '{2000, 1900, 0, 2024};
    foreach (years[i]) begin
      send_load(mk_date(years[i], 2, 28, 23, 59, 59));
      advance_and_update(32'd1000);
    end
  endtask

  task automatic test_out_of_range_load();
    send_load(mk_date(5, 15, 31, 31, 63, 63));
    advance_and_update(32'd1000);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    target = sent_count + n_items;
    while (sent_count < target) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        send_load(near_rollover_date());
        repeat ($urandom_range(1, 6)) advance_and_update(random_step());
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) advance_and_update(random_step());
      end else if (kind < 93) begin
        send_load(random_date());
      end else begin
        update_at($urandom);
      end
    end
  endtask

  initial begin
    src_idle_pct = 31;
    snk_idle_pct = 48;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_tick_threshold();
    test_rollover_cascade();
    test_leap_years();
    test_out_of_range_load();
    test_random_traffic(540);

    src_idle_pct = 48;
    snk_idle_pct = 31;
    test_random_traffic(540);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_traffic(550);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS calendar_clock_counter");
    end else begin
      $display("FAIL calendar_clock_counter");
    end
    $finish;
  end

endmodule
